FILE: sv/hsv_to_rgb_converter_macros.svh
// Assertion macros shared by the HSV to RGB converter modules.
// No dependencies; included by the modules that carry checks.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsv_to_rgb_converter: check failed");

// Implication with a delay given by n, disabled during reset.
`define HSV_ASSERT_LATER(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("hsv_to_rgb_converter: delayed check failed");

`endif

FILE: sv/hsv_pkg.sv
// Shared widths, constants, sector codes and stage structs for the HSV to RGB converter.
// No dependencies.
package hsv_pkg;

   localparam int unsigned HUE_W  = 9;
   localparam int unsigned CH_W   = 8;
   localparam int unsigned REM_W  = 6;
   localparam int unsigned QT_W   = 14;  // holds 15300
   localparam int unsigned PP_W   = 16;  // v * (255 - s)
   localparam int unsigned PQ_W   = 22;  // v * (15300 - s*r)

   localparam int unsigned HUE_MAX        = 360;
   localparam int unsigned DEG_PER_SECTOR = 60;
   localparam int unsigned FULL_SCALE     = 255;
   localparam int unsigned QT_SCALE       = FULL_SCALE * DEG_PER_SECTOR;

   typedef enum logic [2:0] {
      SECT_RY   = 3'd0,
      SECT_YG   = 3'd1,
      SECT_GC   = 3'd2,
      SECT_CB   = 3'd3,
      SECT_BM   = 3'd4,
      SECT_MR   = 3'd5,
      SECT_WRAP = 3'd6   // hue of 360 or more (clamped to 360), behaves like SECT_RY
   } sector_type;

   typedef struct packed {
      logic                valid;
      sector_type          sector;
      logic [REM_W-1:0]    rem;
      logic [CH_W-1:0]     sat;
      logic [CH_W-1:0]     val;
   } split_type;

   typedef struct packed {
      logic                valid;
      sector_type          sector;
      logic [CH_W-1:0]     val;
      logic [PP_W-1:0]     pp;
      logic [PQ_W-1:0]     pq;
      logic [PQ_W-1:0]     pt;
   } shade_type;

   function automatic logic [HUE_W-1:0] sector_base(input sector_type sec);
      logic [HUE_W-1:0] base;
      case (sec)
         SECT_YG:   base = HUE_W'(1 * DEG_PER_SECTOR);
         SECT_GC:   base = HUE_W'(2 * DEG_PER_SECTOR);
         SECT_CB:   base = HUE_W'(3 * DEG_PER_SECTOR);
         SECT_BM:   base = HUE_W'(4 * DEG_PER_SECTOR);
         SECT_MR:   base = HUE_W'(5 * DEG_PER_SECTOR);
         SECT_WRAP: base = HUE_W'(HUE_MAX);
         default:   base = '0;
      endcase
      return base;
   endfunction

endpackage

FILE: sv/hsv_split.sv
// Stage 1: clamps the hue and splits it into sector and remainder.
// Depends on hsv_pkg and the assertion macro header.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_split
   import hsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [HUE_W-1:0]  hue,
   input  logic [CH_W-1:0]   sat,
   input  logic [CH_W-1:0]   val,
   output split_type         split_out
);

   logic [HUE_W-1:0] hue_clamped;
   sector_type       sector_in;
   logic [HUE_W-1:0] rem_wide;
   logic             valid_ff;
   sector_type       sector_ff;
   logic [REM_W-1:0] rem_ff;
   logic [CH_W-1:0]  sat_ff;
   logic [CH_W-1:0]  val_ff;

   always_comb begin
      hue_clamped = (hue > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : hue;
      if (hue_clamped >= HUE_W'(HUE_MAX)) begin
         sector_in = SECT_WRAP;
      end else if (hue_clamped >= HUE_W'(5 * DEG_PER_SECTOR)) begin
         sector_in = SECT_MR;
      end else if (hue_clamped >= HUE_W'(4 * DEG_PER_SECTOR)) begin
         sector_in = SECT_BM;
      end else if (hue_clamped >= HUE_W'(3 * DEG_PER_SECTOR)) begin
         sector_in = SECT_CB;
      end else if (hue_clamped >= HUE_W'(2 * DEG_PER_SECTOR)) begin
         sector_in = SECT_GC;
      end else if (hue_clamped >= HUE_W'(DEG_PER_SECTOR)) begin
         sector_in = SECT_YG;
      end else begin
         sector_in = SECT_RY;
      end
      rem_wide = hue_clamped - sector_base(sector_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_in;
      rem_ff    <= rem_wide[REM_W-1:0];
      sat_ff    <= sat;
      val_ff    <= val;
   end

   assign split_out = '{valid: valid_ff, sector: sector_ff, rem: rem_ff,
                        sat: sat_ff, val: val_ff};

   `HSV_ASSERT_NOW(a_rem_in_sector, clock, reset, valid_ff, rem_ff < REM_W'(DEG_PER_SECTOR))
   `HSV_ASSERT_NOW(a_wrap_rem_zero, clock, reset, valid_ff && (sector_ff == SECT_WRAP),
                   rem_ff == '0)
   `HSV_ASSERT_LATER(a_split_follows, clock, reset, in_valid, 1, valid_ff)

endmodule

FILE: sv/hsv_shade.sv
// Stages 2 and 3: saturation products, then the brightness products of p, q and t.
// Depends on hsv_pkg.
module hsv_shade
   import hsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  split_type  split_in,
   output shade_type  shade_out
);

   // stage A: s*r, s*(60-r), 255-s
   logic [REM_W-1:0] rem_cmp;
   logic             a_valid_ff;
   sector_type       a_sector_ff;
   logic [CH_W-1:0]  a_val_ff;
   logic [QT_W-1:0]  a_sr_ff;
   logic [QT_W-1:0]  a_st_ff;
   logic [CH_W-1:0]  a_pe_ff;

   // stage B: brightness products
   logic [QT_W-1:0]  q_fac;
   logic [QT_W-1:0]  t_fac;
   logic             b_valid_ff;
   sector_type       b_sector_ff;
   logic [CH_W-1:0]  b_val_ff;
   logic [PP_W-1:0]  b_pp_ff;
   logic [PQ_W-1:0]  b_pq_ff;
   logic [PQ_W-1:0]  b_pt_ff;

   assign rem_cmp = REM_W'(DEG_PER_SECTOR) - split_in.rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= split_in.valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_sector_ff <= split_in.sector;
      a_val_ff    <= split_in.val;
      a_sr_ff     <= QT_W'(split_in.sat) * QT_W'(split_in.rem);
      a_st_ff     <= QT_W'(split_in.sat) * QT_W'(rem_cmp);
      a_pe_ff     <= CH_W'(FULL_SCALE) - split_in.sat;
   end

   assign q_fac = QT_W'(QT_SCALE) - a_sr_ff;
   assign t_fac = QT_W'(QT_SCALE) - a_st_ff;

   always_ff @(posedge clock) begin
      b_sector_ff <= a_sector_ff;
      b_val_ff    <= a_val_ff;
      b_pp_ff     <= PP_W'(a_val_ff) * PP_W'(a_pe_ff);
      b_pq_ff     <= PQ_W'(a_val_ff) * PQ_W'(q_fac);
      b_pt_ff     <= PQ_W'(a_val_ff) * PQ_W'(t_fac);
   end

   assign shade_out = '{valid: b_valid_ff, sector: b_sector_ff, val: b_val_ff,
                        pp: b_pp_ff, pq: b_pq_ff, pt: b_pt_ff};

endmodule

FILE: sv/hsv_cdiv.sv
// Division of an unsigned word by a constant: reciprocal estimate, registered,
// then a one-step correction. Depends on the assertion macro header.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_cdiv #(
   parameter int unsigned XW  = 16,
   parameter int unsigned DIV = 255,
   parameter int unsigned QW  = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  logic [XW-1:0]  x,
   output logic [QW-1:0]  quot
);

   // estimate floor(x*M / 2^XW) is the quotient or one less, since x < 2^XW
   localparam int unsigned M  = (2 ** XW) / DIV;
   localparam int unsigned MW = $clog2(M + 1);
   localparam int unsigned PW = XW + ((MW > QW) ? MW : QW);

   logic [PW-1:0] prod;
   logic          valid_ff;
   logic [XW-1:0] x_ff;
   logic [QW-1:0] q0_ff;
   logic [XW-1:0] back;
   logic [XW-1:0] rem;

   assign prod = PW'(x) * PW'(M);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         x_ff  <= x;
         q0_ff <= prod[XW +: QW];
      end
   end

   assign back = XW'(q0_ff) * XW'(DIV);
   assign rem  = x_ff - back;
   assign quot = q0_ff + QW'(rem >= XW'(DIV));

   `HSV_ASSERT_NOW(a_one_correction, clock, reset, valid_ff,
                   {1'b0, rem} < (XW + 1)'(2 * DIV))
   `HSV_ASSERT_NOW(a_no_underflow, clock, reset, valid_ff, back <= x_ff)

endmodule

FILE: sv/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: split, shade products, constant dividers, sector mux.
// Depends on hsv_pkg, hsv_split, hsv_shade, hsv_cdiv and the assertion macro header.
//
//   channel   ports                                    handshake
//   request   req_hue, req_saturation, req_brightness  start / busy
//   response  rsp_red, rsp_green, rsp_blue             rsp_valid strobe
//
// One pixel per cycle; rsp_valid follows start through the split, stage A, stage B, divider and output registers.
// After the split register the stages follow the multiply chain: s*r, then v*(15300 - s*r),
// then the reciprocal multiply of the divide by 15300, then correction plus sector mux.
// busy is never asserted; the pipeline has no stall path since responses
// cannot be held off. Synchronous reset clears all valid bits.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter
   import hsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [CH_W-1:0]   req_saturation,
   input  logic [CH_W-1:0]   req_brightness,
   output logic              rsp_valid,
   output logic [CH_W-1:0]   rsp_red,
   output logic [CH_W-1:0]   rsp_green,
   output logic [CH_W-1:0]   rsp_blue
);

   logic            req_fire;
   split_type       split_s;
   shade_type       shade_s;
   logic [CH_W-1:0] p_val;
   logic [CH_W-1:0] q_val;
   logic [CH_W-1:0] t_val;
   logic            dv_valid_ff;
   sector_type      dv_sector_ff;
   logic [CH_W-1:0] dv_val_ff;
   logic [CH_W-1:0] red_in;
   logic [CH_W-1:0] green_in;
   logic [CH_W-1:0] blue_in;
   logic            out_valid_ff;
   logic [CH_W-1:0] red_ff;
   logic [CH_W-1:0] green_ff;
   logic [CH_W-1:0] blue_ff;

   assign busy     = 1'b0;
   assign req_fire = start && !busy;

   hsv_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .hue       (req_hue),
      .sat       (req_saturation),
      .val       (req_brightness),
      .split_out (split_s)
   );

   hsv_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .split_in  (split_s),
      .shade_out (shade_s)
   );

   hsv_cdiv #(.XW(PP_W), .DIV(FULL_SCALE), .QW(CH_W)) u_div_p (
      .clock    (clock),
      .reset    (reset),
      .in_valid (shade_s.valid),
      .x        (shade_s.pp),
      .quot     (p_val)
   );

   hsv_cdiv #(.XW(PQ_W), .DIV(QT_SCALE), .QW(CH_W)) u_div_q (
      .clock    (clock),
      .reset    (reset),
      .in_valid (shade_s.valid),
      .x        (shade_s.pq),
      .quot     (q_val)
   );

   hsv_cdiv #(.XW(PQ_W), .DIV(QT_SCALE), .QW(CH_W)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .in_valid (shade_s.valid),
      .x        (shade_s.pt),
      .quot     (t_val)
   );

   // sideband travels alongside the divider register
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         dv_valid_ff  <= shade_s.valid;
         out_valid_ff <= dv_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dv_sector_ff <= shade_s.sector;
      dv_val_ff    <= shade_s.val;
   end

   always_comb begin
      case (dv_sector_ff)
         SECT_YG: begin
            red_in = q_val;     green_in = dv_val_ff; blue_in = p_val;
         end
         SECT_GC: begin
            red_in = p_val;     green_in = dv_val_ff; blue_in = t_val;
         end
         SECT_CB: begin
            red_in = p_val;     green_in = q_val;     blue_in = dv_val_ff;
         end
         SECT_BM: begin
            red_in = t_val;     green_in = p_val;     blue_in = dv_val_ff;
         end
         SECT_MR: begin
            red_in = dv_val_ff; green_in = p_val;     blue_in = q_val;
         end
         default: begin
            // red-to-yellow sector and the 360 wrap
            red_in = dv_val_ff; green_in = t_val;     blue_in = p_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   `HSV_ASSERT_LATER(a_fixed_latency, clock, reset, req_fire, 5, rsp_valid)
   `HSV_ASSERT_NOW(a_no_spurious_rsp, clock, reset, rsp_valid, $past(req_fire, 5))
   `HSV_ASSERT_NOW(a_shades_below_value, clock, reset, dv_valid_ff,
                   (p_val <= dv_val_ff) && (q_val <= dv_val_ff) && (t_val <= dv_val_ff))

endmodule
